/* src/lut3d_trilinear_color_map_unit_assert.svh */
`ifndef LUT3D_TRILINEAR_COLOR_MAP_UNIT_ASSERT_SVH
`define LUT3D_TRILINEAR_COLOR_MAP_UNIT_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define L3D_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define L3D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that is also checked across reset
`define L3D_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/l3d_pkg.sv */
package l3d_pkg;

    // table geometry
    localparam int MAX_POINTS = 17;
    localparam int ENTRY_BITS = 16;
    localparam int FRAC_BITS  = 12;
    localparam int DEPTH      = MAX_POINTS * MAX_POINTS * MAX_POINTS;
    localparam int AW         = $clog2(DEPTH);
    localparam int NW         = $clog2(MAX_POINTS + 1);
    localparam int NN_W       = $clog2(MAX_POINTS * MAX_POINTS + 1);
    localparam int CORNERS    = 8;

    // fixed field widths
    localparam int CMD_W      = 1;
    localparam int IDX_W      = 13;
    localparam int ENT_W      = 16;
    localparam int CH_W       = 8;
    localparam int LUT_SIZE_W = 5;
    localparam logic [LUT_SIZE_W-1:0] LUT_SIZE_RESET = LUT_SIZE_W'(17);

    // item commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 1'b1;

    // blend word widths after each axis
    localparam int W1    = ENTRY_BITS + 9;
    localparam int W2    = ENTRY_BITS + 17;
    localparam int W3    = ENTRY_BITS + 26;
    localparam int NUM_W = W3 + 1;

    // rounding and division by 255^2 * 2^FRAC_BITS
    localparam int Q_IN_W      = 24;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 40;
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(16909061);
    localparam logic [Q_IN_W-1:0]  SAT_LIMIT = Q_IN_W'(16646400);
    localparam logic [NUM_W-1:0]   ROUND_ADD = NUM_W'(65025) << (FRAC_BITS - 1);

    // one table entry, channel 0 red, 1 green, 2 blue
    typedef logic [2:0][ENTRY_BITS-1:0] t_entry;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] entry_index;
        t_entry           entry;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
        logic             last;
    } t_in_item;

    // address stage handed from the index pipeline to the table banks
    typedef struct packed {
        logic             valid;
        logic             pix;
        logic [AW-1:0]    base;
        logic [7:0]       dr;
        logic [7:0]       dg;
        logic [7:0]       db;
        logic [CH_W-1:0]  alpha;
        logic             last;
        logic [IDX_W-1:0] widx;
        t_entry           wdata;
    } t_addr_word;

    // side data that travels beside the table read
    typedef struct packed {
        logic            valid;
        logic [7:0]      dr;
        logic [7:0]      dg;
        logic [7:0]      db;
        logic [CH_W-1:0] alpha;
        logic            last;
    } t_blend_word;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            last;
    } t_px_out;

endpackage

/* src/l3d_in_if.sv */
interface l3d_in_if import l3d_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       cmd;
    logic [IDX_W-1:0]       entry_index;
    logic signed [ENT_W-1:0] entry_red;
    logic signed [ENT_W-1:0] entry_green;
    logic signed [ENT_W-1:0] entry_blue;
    logic [CH_W-1:0]        in_red;
    logic [CH_W-1:0]        in_green;
    logic [CH_W-1:0]        in_blue;
    logic [CH_W-1:0]        in_alpha;
    logic                   in_last;

    modport source (
        output valid, cmd, entry_index, entry_red, entry_green, entry_blue,
               in_red, in_green, in_blue, in_alpha, in_last,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, entry_red, entry_green, entry_blue,
               in_red, in_green, in_blue, in_alpha, in_last,
        output ready
    );
endinterface

/* src/l3d_out_if.sv */
interface l3d_out_if import l3d_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
    logic            out_last;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha, out_last,
        output ready
    );
endinterface

/* src/l3d_cfg_if.sv */
interface l3d_cfg_if import l3d_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [LUT_SIZE_W-1:0] lut_size;

    modport source (output valid, lut_size, input ready);
    modport sink (input valid, lut_size, output ready);
endinterface

/* src/l3d_ram.sv */
module l3d_ram #(
    parameter int DEPTH_P = 4913,
    parameter int WIDTH_P = 48
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH_P)-1:0] i_waddr,
    input  logic [WIDTH_P-1:0]         i_wdata,
    input  logic [$clog2(DEPTH_P)-1:0] i_raddr,
    output logic [WIDTH_P-1:0]         o_rdata
);
    logic [WIDTH_P-1:0] mem [DEPTH_P];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_en) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

/* src/l3d_index.sv */
module l3d_index import l3d_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_take,
    input  t_in_item      i_item,
    input  logic [NW-1:0] i_n,
    output t_addr_word    o_addr
);
    localparam int T_W = CH_W + NW;

    typedef struct packed {
        logic             valid;
        logic             pix;
        logic [T_W-1:0]   tr;
        logic [T_W-1:0]   tg;
        logic [T_W-1:0]   tb;
        logic [CH_W-1:0]  alpha;
        logic             last;
        logic [IDX_W-1:0] widx;
        t_entry           wdata;
    } t_scale_word;

    typedef struct packed {
        logic             valid;
        logic             pix;
        logic [NW-1:0]    r0;
        logic [NW-1:0]    g0;
        logic [NW-1:0]    b0;
        logic [7:0]       dr;
        logic [7:0]       dg;
        logic [7:0]       db;
        logic [CH_W-1:0]  alpha;
        logic             last;
        logic [IDX_W-1:0] widx;
        t_entry           wdata;
    } t_split_word;

    typedef struct packed {
        logic             valid;
        logic             pix;
        logic [AW-1:0]    bg;
        logic [NW-1:0]    r0;
        logic [7:0]       dr;
        logic [7:0]       dg;
        logic [7:0]       db;
        logic [CH_W-1:0]  alpha;
        logic             last;
        logic [IDX_W-1:0] widx;
        t_entry           wdata;
    } t_row_word;

    t_scale_word r_s1, n_s1;
    t_split_word r_s2, n_s2;
    t_row_word   r_s3, n_s3;
    t_addr_word  r_s4, n_s4;

    // floor(t/255) for any T_W-bit t, capped at n-2
    function automatic logic [NW-1:0] split_idx(input logic [T_W-1:0] t,
                                                input logic [NW-1:0] cap);
        logic [T_W+1:0] q;
        q = ((T_W+2)'(t) + (T_W+2)'(t >> 8) + (T_W+2)'(1)) >> 8;
        split_idx = (q > (T_W+2)'(cap)) ? cap : NW'(q);
    endfunction

    function automatic logic [7:0] split_frac(input logic [T_W-1:0] t,
                                              input logic [NW-1:0] i0);
        logic [T_W-1:0] base;
        base = (T_W'(i0) << 8) - T_W'(i0);
        split_frac = 8'(t - base);
    endfunction

    // stage 1: scale each channel by n-1
    always_comb begin
        n_s1.valid = i_take;
        n_s1.pix   = (i_item.cmd == CMD_PIXEL);
        n_s1.tr    = T_W'(i_item.red) * T_W'(i_n - NW'(1));
        n_s1.tg    = T_W'(i_item.green) * T_W'(i_n - NW'(1));
        n_s1.tb    = T_W'(i_item.blue) * T_W'(i_n - NW'(1));
        n_s1.alpha = i_item.alpha;
        n_s1.last  = i_item.last;
        n_s1.widx  = i_item.entry_index;
        n_s1.wdata = i_item.entry;
    end

    // stage 2: cell index and fraction per axis
    always_comb begin
        n_s2.valid = r_s1.valid;
        n_s2.pix   = r_s1.pix;
        n_s2.r0    = split_idx(r_s1.tr, i_n - NW'(2));
        n_s2.g0    = split_idx(r_s1.tg, i_n - NW'(2));
        n_s2.b0    = split_idx(r_s1.tb, i_n - NW'(2));
        n_s2.dr    = split_frac(r_s1.tr, n_s2.r0);
        n_s2.dg    = split_frac(r_s1.tg, n_s2.g0);
        n_s2.db    = split_frac(r_s1.tb, n_s2.b0);
        n_s2.alpha = r_s1.alpha;
        n_s2.last  = r_s1.last;
        n_s2.widx  = r_s1.widx;
        n_s2.wdata = r_s1.wdata;
    end

    // stage 3: blue*n + green
    always_comb begin
        n_s3.valid = r_s2.valid;
        n_s3.pix   = r_s2.pix;
        n_s3.bg    = AW'(r_s2.b0) * AW'(i_n) + AW'(r_s2.g0);
        n_s3.r0    = r_s2.r0;
        n_s3.dr    = r_s2.dr;
        n_s3.dg    = r_s2.dg;
        n_s3.db    = r_s2.db;
        n_s3.alpha = r_s2.alpha;
        n_s3.last  = r_s2.last;
        n_s3.widx  = r_s2.widx;
        n_s3.wdata = r_s2.wdata;
    end

    // stage 4: flat base index of the low corner
    always_comb begin
        n_s4.valid = r_s3.valid;
        n_s4.pix   = r_s3.pix;
        n_s4.base  = r_s3.bg * AW'(i_n) + AW'(r_s3.r0);
        n_s4.dr    = r_s3.dr;
        n_s4.dg    = r_s3.dg;
        n_s4.db    = r_s3.db;
        n_s4.alpha = r_s3.alpha;
        n_s4.last  = r_s3.last;
        n_s4.widx  = r_s3.widx;
        n_s4.wdata = r_s3.wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_s4.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    assign o_addr = r_s4;
endmodule

/* src/l3d_blend.sv */
module l3d_blend import l3d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_blend_word i_side,
    input  t_entry      i_corner [CORNERS],
    output logic        o_valid,
    output t_px_out     o_px
);
    typedef logic signed [3:0][W1-1:0] t_v1;
    typedef logic signed [1:0][W2-1:0] t_v2;

    logic                  r_v6, r_v7, r_v8, r_v9, r_out_valid;
    logic [7:0]            r_dg6, r_db6, r_db7;
    logic [CH_W-1:0]       r_a6, r_a7, r_a8, r_a9;
    logic                  r_l6, r_l7, r_l8, r_l9;
    t_v1                   r_v1 [3], n_v1 [3];
    t_v2                   r_v2 [3], n_v2 [3];
    logic signed [W3-1:0]  r_s [3], n_s [3];
    logic [Q_IN_W-1:0]     r_x [3], n_x [3];
    logic [2:0]            r_neg, n_neg, r_sat, n_sat;
    logic [CH_W-1:0]       n_q [3];
    t_px_out               r_px;

    // red axis: four lerps per channel
    always_comb begin
        logic signed [W1-1:0] a1, b1;
        for (int ch = 0; ch < 3; ch++) begin
            for (int j = 0; j < 4; j++) begin
                a1 = W1'($signed(i_corner[2*j][ch]));
                b1 = W1'($signed(i_corner[2*j+1][ch]));
                n_v1[ch][j] = (a1 <<< 8) - a1 + (b1 - a1) * $signed({1'b0, i_side.dr});
            end
        end
    end

    // green axis: two lerps per channel
    always_comb begin
        logic signed [W2-1:0] a2, b2;
        for (int ch = 0; ch < 3; ch++) begin
            for (int m = 0; m < 2; m++) begin
                a2 = W2'($signed(r_v1[ch][2*m]));
                b2 = W2'($signed(r_v1[ch][2*m+1]));
                n_v2[ch][m] = (a2 <<< 8) - a2 + (b2 - a2) * $signed({1'b0, r_dg6});
            end
        end
    end

    // blue axis: final lerp per channel
    always_comb begin
        logic signed [W3-1:0] a3, b3;
        for (int ch = 0; ch < 3; ch++) begin
            a3 = W3'($signed(r_v2[ch][0]));
            b3 = W3'($signed(r_v2[ch][1]));
            n_s[ch] = (a3 <<< 8) - a3 + (b3 - a3) * $signed({1'b0, r_db7});
        end
    end

    // add half, drop the fraction bits, flag negative and saturating sums
    always_comb begin
        logic [NUM_W-1:0] num;
        for (int ch = 0; ch < 3; ch++) begin
            num = NUM_W'(r_s[ch]) + ROUND_ADD;
            n_neg[ch] = num[NUM_W-1];
            n_sat[ch] = (num[NUM_W-2:FRAC_BITS] >= (NUM_W-1-FRAC_BITS)'(SAT_LIMIT));
            n_x[ch]   = num[FRAC_BITS+Q_IN_W-1:FRAC_BITS];
        end
    end

    // divide by 255^2 through the reciprocal, then clamp
    always_comb begin
        logic [Q_IN_W+RECIP_W-1:0] prod;
        for (int ch = 0; ch < 3; ch++) begin
            prod = (Q_IN_W+RECIP_W)'(r_x[ch]) * (Q_IN_W+RECIP_W)'(RECIP);
            if (r_neg[ch]) begin
                n_q[ch] = '0;
            end else if (r_sat[ch]) begin
                n_q[ch] = '1;
            end else begin
                n_q[ch] = prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
            end
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6        <= 1'b0;
            r_v7        <= 1'b0;
            r_v8        <= 1'b0;
            r_v9        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_v6        <= i_side.valid;
            r_v7        <= r_v6;
            r_v8        <= r_v7;
            r_v9        <= r_v8;
            r_out_valid <= r_v9;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v1  <= n_v1;
            r_dg6 <= i_side.dg;
            r_db6 <= i_side.db;
            r_a6  <= i_side.alpha;
            r_l6  <= i_side.last;
            r_v2  <= n_v2;
            r_db7 <= r_db6;
            r_a7  <= r_a6;
            r_l7  <= r_l6;
            r_s   <= n_s;
            r_a8  <= r_a7;
            r_l8  <= r_l7;
            r_x   <= n_x;
            r_neg <= n_neg;
            r_sat <= n_sat;
            r_a9  <= r_a8;
            r_l9  <= r_l8;
            r_px.red   <= n_q[0];
            r_px.green <= n_q[1];
            r_px.blue  <= n_q[2];
            r_px.alpha <= r_a9;
            r_px.last  <= r_l9;
        end
    end

    assign o_valid = r_out_valid;
    assign o_px    = r_px;
endmodule

/* src/lut3d_trilinear_color_map_unit.sv */
// 3D color table mapper with trilinear blending.
// i_px carries items: a load item (cmd 0) writes one table entry at
// entry_index = blue*N*N + green*N + red; a pixel item (cmd 1) maps its
// red/green/blue through the table and yields one transfer on o_px with
// alpha and last copied. Load items produce no output transfer.
// i_cfg sets lut_size (N, clamped to 2..17); write it only while idle.
// The table is eight copies of the same memory, one per cube corner, so
// all eight corners are read in the same cycle and one item is taken per cycle.
// Throughput: one item per cycle while o_px is not stalled.
// Stall: the whole pipeline holds while o_px shows valid without ready;
// i_px.ready is low only then, and bubbles in flight hold as well.
// Reset clears all valid flags and sets lut_size to 17. Table contents are
// not cleared; a pixel must only touch entries already loaded.
module lut3d_trilinear_color_map_unit import l3d_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    l3d_in_if.sink       i_px,
    l3d_cfg_if.sink      i_cfg,
    l3d_out_if.source    o_px
);
    logic                  en;
    logic                  take;
    logic                  we;
    logic                  out_valid;
    logic [LUT_SIZE_W-1:0] r_lut_size;
    logic [NW-1:0]         r_n, n_n;
    logic [NN_W-1:0]       r_nn;
    logic [AW-1:0]         r_off [CORNERS], n_off [CORNERS];
    t_in_item              item;
    t_addr_word            addr;
    t_blend_word           r_side;
    t_entry                corner [CORNERS];
    t_px_out               px;

    // global advance: move whenever the output slot is free or drains
    assign en   = !out_valid || o_px.ready;
    assign take = i_px.valid && en;
    assign i_px.ready  = en;
    assign i_cfg.ready = 1'b1;

    // size register and effective size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lut_size <= LUT_SIZE_RESET;
        end else if (i_cfg.valid) begin
            r_lut_size <= i_cfg.lut_size;
        end
    end

    always_comb begin
        priority if (r_lut_size < LUT_SIZE_W'(2)) begin
            n_n = NW'(2);
        end else if (32'(r_lut_size) > MAX_POINTS) begin
            n_n = NW'(MAX_POINTS);
        end else begin
            n_n = NW'(r_lut_size);
        end
    end

    // corner offsets from the low corner: bit 0 red, bit 1 green, bit 2 blue
    always_comb begin
        for (int k = 0; k < CORNERS; k++) begin
            n_off[k] = ((k & 1) != 0 ? AW'(1) : AW'(0))
                     + ((k & 2) != 0 ? AW'(r_n) : AW'(0))
                     + ((k & 4) != 0 ? AW'(r_nn) : AW'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_nn  <= NN_W'(r_n) * NN_W'(r_n);
        r_off <= n_off;
    end

    // pack the input transfer
    always_comb begin
        item.cmd         = i_px.cmd;
        item.entry_index = i_px.entry_index;
        item.entry[0]    = ENTRY_BITS'(i_px.entry_red);
        item.entry[1]    = ENTRY_BITS'(i_px.entry_green);
        item.entry[2]    = ENTRY_BITS'(i_px.entry_blue);
        item.red         = i_px.in_red;
        item.green       = i_px.in_green;
        item.blue        = i_px.in_blue;
        item.alpha       = i_px.in_alpha;
        item.last        = i_px.in_last;
    end

    l3d_index u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_take  (take),
        .i_item  (item),
        .i_n     (n_n),
        .o_addr  (addr)
    );

    // loads write all copies at the same pipeline point as pixel reads
    assign we = en && addr.valid && !addr.pix && (32'(addr.widx) < DEPTH);

    for (genvar k = 0; k < CORNERS; k++) begin : g_bank
        l3d_ram #(
            .DEPTH_P (DEPTH),
            .WIDTH_P ($bits(t_entry))
        ) u_ram (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_we    (we),
            .i_waddr (AW'(addr.widx)),
            .i_wdata (addr.wdata),
            .i_raddr (addr.base + r_off[k]),
            .o_rdata (corner[k])
        );
    end

    // side data aligned with the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (en) begin
            r_side.valid <= addr.valid && addr.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side.dr    <= addr.dr;
            r_side.dg    <= addr.dg;
            r_side.db    <= addr.db;
            r_side.alpha <= addr.alpha;
            r_side.last  <= addr.last;
        end
    end

    l3d_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_side   (r_side),
        .i_corner (corner),
        .o_valid  (out_valid),
        .o_px     (px)
    );

    assign o_px.valid     = out_valid;
    assign o_px.out_red   = px.red;
    assign o_px.out_green = px.green;
    assign o_px.out_blue  = px.blue;
    assign o_px.out_alpha = px.alpha;
    assign o_px.out_last  = px.last;
endmodule

/* src/l3d_checker.sv */
`include "lut3d_trilinear_color_map_unit_assert.svh"

module l3d_checker import l3d_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_ready,
    input logic            i_cfg_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic [CH_W-1:0] i_out_red,
    input logic [CH_W-1:0] i_out_alpha
);
    // input side opens exactly when the output slot can move
    `L3D_ASSERT_NOW(a_ready_follows_out, i_clk, i_rst_n, 1'b1, i_in_ready == (!i_out_valid || i_out_ready), "input ready does not track output slot")

    // a stalled output transfer keeps its red and alpha values
    `L3D_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_red) && $stable(i_out_alpha), "stalled output changed")

    // no result straight out of reset
    `L3D_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid, "output valid right after reset")

    // configuration is always taken
    `L3D_ASSERT_NOW(a_cfg_ready, i_clk, i_rst_n, 1'b1, i_cfg_ready, "config port not ready")
endmodule

bind lut3d_trilinear_color_map_unit l3d_checker u_l3d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_px.ready),
    .i_cfg_ready (i_cfg.ready),
    .i_out_valid (o_px.valid),
    .i_out_ready (o_px.ready),
    .i_out_red   (o_px.out_red),
    .i_out_alpha (o_px.out_alpha)
);
